// File: rtl/core/json_array_object_splitter_macros.svh
// ---------------------------------------------------------------------------
// json array object splitter - assertion macros
// concurrent assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef JSON_ARRAY_OBJECT_SPLITTER_MACROS_SVH
`define JSON_ARRAY_OBJECT_SPLITTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define JAOS_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("jaos assertion failed");

// next-cycle implication, disabled during reset
`define JAOS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("jaos assertion failed");

`endif

// File: rtl/core/jaos_pkg.sv
// ---------------------------------------------------------------------------
// jaos_pkg
// types, codes and helper functions of the json array object splitter
// ---------------------------------------------------------------------------
`default_nettype none

package jaos_pkg;

	localparam int DEPTH_BITS = 8;

	localparam logic [3:0] PH_SEEK_KEY   = 4'd0;
	localparam logic [3:0] PH_COLON      = 4'd1;
	localparam logic [3:0] PH_BRACKET    = 4'd2;
	localparam logic [3:0] PH_FIRST      = 4'd3;
	localparam logic [3:0] PH_IN_OBJECT  = 4'd4;
	localparam logic [3:0] PH_AFTER_OBJ  = 4'd5;
	localparam logic [3:0] PH_NEXT_OBJ   = 4'd6;
	localparam logic [3:0] PH_DONE_OK    = 4'd7;
	localparam logic [3:0] PH_DONE_EMPTY = 4'd8;
	localparam logic [3:0] PH_ERROR      = 4'd9;

	localparam logic [2:0] ST_RUNNING    = 3'd0;
	localparam logic [2:0] ST_OK         = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_ERROR      = 3'd4;

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [2:0] KEY_LEN = 3'd7;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	typedef struct packed {
		logic [3:0]            phase;
		logic [2:0]            key_pos;
		logic [DEPTH_BITS-1:0] depth;
	} state_t;

	typedef struct packed {
		logic [7:0] object_byte;
		logic       byte_valid;
		logic       object_last;
		logic       response_done;
		logic [2:0] status;
	} result_t;

	localparam state_t STATE_RESET = '{phase: PH_SEEK_KEY, key_pos: '0, depth: '0};

	function automatic logic [7:0] key_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = CH_QUOTE;
			3'd1: ch = 8'h69;
			3'd2: ch = 8'h74;
			3'd3: ch = 8'h65;
			3'd4: ch = 8'h6D;
			3'd5: ch = 8'h73;
			3'd6: ch = CH_QUOTE;
			default: ch = CH_QUOTE;
		endcase
		return ch;
	endfunction

	function automatic logic is_blank(input logic [7:0] ch);
		return ch inside {8'h20, [8'h09:8'h0D]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/jaos_if.sv
// ---------------------------------------------------------------------------
// jaos channel interfaces
// valid/ready channels for response bytes in and object words out
// ---------------------------------------------------------------------------
`default_nettype none

interface jaos_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface jaos_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] object_byte;
	logic       byte_valid;
	logic       object_last;
	logic       response_done;
	logic [2:0] status;

	modport source (output valid, output object_byte, output byte_valid, output object_last,
		output response_done, output status, input ready);
	modport sink (input valid, input object_byte, input byte_valid, input object_last,
		input response_done, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/json_array_object_splitter.sv
// ---------------------------------------------------------------------------
// json_array_object_splitter
// splits the objects of the "items" array out of a json response byte stream
// ---------------------------------------------------------------------------
// channel | dir | words                                     | handshake
// req     | in  | operation, data_byte                      | valid/ready
// rsp     | out | object_byte, byte_valid, object_last,     | valid/ready
//         |     | response_done, status                     |
//
// one word in, one word out, one word per cycle sustained while rsp is ready
// the result is registered in the output buffer, via its skid register when rsp stalls
// a two-entry output buffer keeps req ready through one stalled result
// reset clears the parser to key search and empties the output buffer
// ---------------------------------------------------------------------------
`default_nettype none

module json_array_object_splitter (
	input  logic        clk,
	input  logic        arst_n,
	jaos_in_if.sink     req,
	jaos_out_if.source  rsp
);

	jaos_pkg::state_t  state_q;
	jaos_pkg::state_t  state_nxt;
	jaos_pkg::result_t step_res;
	jaos_pkg::result_t out_data;
	logic              can_push;
	logic              accept;

	assign req.ready = can_push;
	assign accept    = req.valid && can_push;

	jaos_step u_step (
		.cur       (state_q),
		.operation (req.operation),
		.data_byte (req.data_byte),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jaos_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	jaos_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.can_push  (can_push),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

	assign rsp.object_byte   = out_data.object_byte;
	assign rsp.byte_valid    = out_data.byte_valid;
	assign rsp.object_last   = out_data.object_last;
	assign rsp.response_done = out_data.response_done;
	assign rsp.status        = out_data.status;

endmodule

`default_nettype wire

// File: rtl/core/jaos_step.sv
// ---------------------------------------------------------------------------
// jaos_step
// next-state and result logic for one response byte or finish word
// ---------------------------------------------------------------------------
`default_nettype none

module jaos_step (
	input  jaos_pkg::state_t  cur,
	input  logic              operation,
	input  logic [7:0]        data_byte,
	output jaos_pkg::state_t  nxt,
	output jaos_pkg::result_t res
);

	logic [2:0] pos;
	logic       blank;

	assign pos   = (cur.key_pos < jaos_pkg::KEY_LEN) ? cur.key_pos : 3'd0;
	assign blank = jaos_pkg::is_blank(data_byte);

	always_comb begin
		nxt               = cur;
		res               = '0;
		res.status        = jaos_pkg::ST_RUNNING;
		if (operation == jaos_pkg::OP_FINISH) begin
			res.response_done = 1'b1;
			case (cur.phase)
				jaos_pkg::PH_DONE_OK:    res.status = jaos_pkg::ST_OK;
				jaos_pkg::PH_DONE_EMPTY: res.status = jaos_pkg::ST_EMPTY;
				jaos_pkg::PH_ERROR,
				jaos_pkg::PH_SEEK_KEY:   res.status = jaos_pkg::ST_ERROR;
				default:                 res.status = jaos_pkg::ST_INCOMPLETE;
			endcase
			nxt = jaos_pkg::STATE_RESET;
		end else begin
			case (cur.phase)
				jaos_pkg::PH_SEEK_KEY: begin
					if (data_byte == jaos_pkg::key_char(pos)) begin
						if (pos == jaos_pkg::KEY_LEN - 3'd1) begin
							nxt.phase   = jaos_pkg::PH_COLON;
							nxt.key_pos = 3'd0;
						end else begin
							nxt.key_pos = pos + 3'd1;
						end
					end else begin
						nxt.key_pos = (data_byte == jaos_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
					end
				end
				jaos_pkg::PH_COLON: begin
					if (!blank)
						nxt.phase = (data_byte == jaos_pkg::CH_COLON) ?
							jaos_pkg::PH_BRACKET : jaos_pkg::PH_ERROR;
				end
				jaos_pkg::PH_BRACKET: begin
					if (!blank)
						nxt.phase = (data_byte == jaos_pkg::CH_LBRACK) ?
							jaos_pkg::PH_FIRST : jaos_pkg::PH_ERROR;
				end
				jaos_pkg::PH_FIRST,
				jaos_pkg::PH_NEXT_OBJ: begin
					if (!blank) begin
						if (data_byte == jaos_pkg::CH_LBRACE) begin
							nxt.depth      = jaos_pkg::DEPTH_BITS'(1);
							nxt.phase      = jaos_pkg::PH_IN_OBJECT;
							res.byte_valid = 1'b1;
						end else if (data_byte == jaos_pkg::CH_RBRACK &&
							cur.phase == jaos_pkg::PH_FIRST) begin
							nxt.phase = jaos_pkg::PH_DONE_EMPTY;
						end else begin
							nxt.phase = jaos_pkg::PH_ERROR;
						end
					end
				end
				jaos_pkg::PH_IN_OBJECT: begin
					res.byte_valid = 1'b1;
					if (data_byte == jaos_pkg::CH_LBRACE) begin
						if (cur.depth == jaos_pkg::DEPTH_MAX) begin
							nxt.phase      = jaos_pkg::PH_ERROR;
							res.byte_valid = 1'b0;
						end else begin
							nxt.depth = cur.depth + jaos_pkg::DEPTH_BITS'(1);
						end
					end else if (data_byte == jaos_pkg::CH_RBRACE) begin
						if (cur.depth <= jaos_pkg::DEPTH_BITS'(1)) begin
							nxt.depth       = '0;
							nxt.phase       = jaos_pkg::PH_AFTER_OBJ;
							res.object_last = 1'b1;
						end else begin
							nxt.depth = cur.depth - jaos_pkg::DEPTH_BITS'(1);
						end
					end
				end
				jaos_pkg::PH_AFTER_OBJ: begin
					if (!blank) begin
						if (data_byte == jaos_pkg::CH_COMMA)
							nxt.phase = jaos_pkg::PH_NEXT_OBJ;
						else if (data_byte == jaos_pkg::CH_RBRACK)
							nxt.phase = jaos_pkg::PH_DONE_OK;
						else
							nxt.phase = jaos_pkg::PH_ERROR;
					end
				end
				default: begin
				end
			endcase
		end
		res.object_byte = res.byte_valid ? data_byte : 8'h00;
	end

endmodule

`default_nettype wire

// File: rtl/core/jaos_out_buf.sv
// ---------------------------------------------------------------------------
// jaos_out_buf
// result register with a skid stage so input keeps flowing through one stalled result
// ---------------------------------------------------------------------------
`default_nettype none

module jaos_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jaos_pkg::result_t push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output jaos_pkg::result_t out_data
);

	logic              main_v_q;
	logic              skid_v_q;
	jaos_pkg::result_t main_q;
	jaos_pkg::result_t skid_q;
	logic              take;

	assign take      = main_v_q && out_ready;
	assign can_push  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (!main_v_q) begin
			main_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (!main_v_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/jaos_checker.sv
// ---------------------------------------------------------------------------
// jaos_checker
// port-level checks on the result channel of the splitter
// ---------------------------------------------------------------------------
`default_nettype none

`include "json_array_object_splitter_macros.svh"

module jaos_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] object_byte,
	input logic       byte_valid,
	input logic       object_last,
	input logic       response_done,
	input logic [2:0] status
);

	`JAOS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable({object_byte, byte_valid, object_last, response_done, status}))
	`JAOS_ASSERT_IMPLY(a_done_no_data, clk, arst_n, rsp_valid && response_done, !byte_valid && !object_last && status != jaos_pkg::ST_RUNNING)
	`JAOS_ASSERT_IMPLY(a_running_status, clk, arst_n, rsp_valid && !response_done, status == jaos_pkg::ST_RUNNING)
	`JAOS_ASSERT_IMPLY(a_last_brace, clk, arst_n, rsp_valid && object_last, byte_valid && object_byte == jaos_pkg::CH_RBRACE)
	`JAOS_ASSERT_IMPLY(a_idle_byte_zero, clk, arst_n, rsp_valid && !byte_valid, object_byte == 8'h00)

endmodule

bind json_array_object_splitter jaos_checker u_jaos_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.object_byte   (rsp.object_byte),
	.byte_valid    (rsp.byte_valid),
	.object_last   (rsp.object_last),
	.response_done (rsp.response_done),
	.status        (rsp.status)
);

`default_nettype wire
